// ===== hw/rtl/mcdsd_pkg.sv =====
package mcdsd_pkg;

	localparam int MAX_CHANNELS = 128;
	localparam int CH_W = $clog2(MAX_CHANNELS);
	localparam int CNT_W = CH_W + 1;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_NUM_CHANNELS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_CHECK = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_POINTS = 2'd2;

	localparam logic [7:0] NUM_CHANNELS_RESET = 8'd30;

	localparam int IN_DATA_W = 8;
	localparam int OUT_DATA_W = 24;

	typedef struct packed {
		logic        point_all_zero;
		logic        last_of_point;
		logic [6:0]  channel;
		logic [15:0] sample;
	} result_t;

endpackage

// ===== hw/rtl/multichannel_delta_sample_decoder.sv =====
// Multichannel delta sample decoder.
// The input stream (s_*) carries one byte of the compressed stream per transfer.
// The output stream (m_*) carries one decoded sample per transfer: tdata holds
// the signed 16-bit count and the channel index, tlast marks the last channel
// of a point, and tuser flags an all-zero point that downstream should drop.
// A high byte of an absolute word produces no output; its low byte does.
// A result is registered in the output register, or in the skid register when
// the receiver stalls, and the block takes one byte per cycle while the skid
// register is empty. The rate is set by the per-channel value table, which is
// read ahead at the channel that the next byte will use, with a bypass for
// back-to-back writes to the same channel.
// Configuration is written through cfg_we, cfg_index and cfg_data while the
// stream is idle.
// Reset clears the control state: the first point is absolute, the channel
// index is zero and the output is empty. Table contents are undefined until
// an absolute word has written each channel.
// When the receiver stalls, a second result is held in a skid register, and
// s_tready falls only once both output registers are full.
module multichannel_delta_sample_decoder (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [mcdsd_pkg::IN_DATA_W-1:0]     s_tdata,  // [7:0] data_byte
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [mcdsd_pkg::OUT_DATA_W-1:0]    m_tdata,  // [15:0] sample, [22:16] channel
	output logic                                m_tlast,
	output logic                                m_tuser,  // [0] point_all_zero
	input  logic                                cfg_we,
	input  logic [mcdsd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mcdsd_pkg::CFG_DATA_W-1:0]    cfg_data
);

	import mcdsd_pkg::*;

	logic [7:0]      num_channels_q;
	logic            zero_check_q;
	logic [15:0]     segment_points_q;

	logic [CH_W-1:0] ch_q;
	logic            pend_q;
	logic [7:0]      hi_q;
	logic            abs_q;
	logic            allz_q;
	logic [15:0]     seg_q;

	logic            byp_q;
	logic [15:0]     byp_data_q;

	logic            out_v_q;
	result_t         out_q;
	logic            sk_v_q;
	result_t         sk_q;

	logic            acc;
	logic [7:0]      data_byte;
	logic            start_abs;
	logic [15:0]     ram_rdata;
	logic [15:0]     last_val;
	logic [15:0]     delta;
	logic [15:0]     word;
	logic [CNT_W-1:0] n_act;
	logic [CNT_W-1:0] ch_inc;
	logic            last;
	logic            allz_n;
	logic            drop;
	logic [15:0]     seg_inc;
	logic [CH_W-1:0] ch_d;
	logic            wr_en;
	logic            pop;
	result_t         res;

	assign data_byte = s_tdata;
	assign s_tready = !sk_v_q;
	assign acc = s_tvalid && s_tready;
	assign start_abs = !pend_q && (data_byte[7] || abs_q);
	assign wr_en = acc && !start_abs;

	assign last_val = byp_q ? byp_data_q : ram_rdata;
	assign delta = {{9{data_byte[6]}}, data_byte[6:0]};

	always_comb begin
		if (pend_q) begin
			word = {hi_q[7] & hi_q[6], hi_q[6:0], data_byte};
		end else begin
			word = last_val + delta;
		end
	end

	always_comb begin
		if (num_channels_q == 8'd0) begin
			n_act = CNT_W'(1);
		end else if ({1'b0, num_channels_q} > 9'(MAX_CHANNELS)) begin
			n_act = CNT_W'(MAX_CHANNELS);
		end else begin
			n_act = CNT_W'(num_channels_q);
		end
	end

	assign ch_inc = {1'b0, ch_q} + CNT_W'(1);
	assign last = ch_inc >= n_act;
	assign allz_n = allz_q && (word == 16'd0);
	assign drop = zero_check_q && allz_n;
	assign seg_inc = seg_q + 16'd1;

	always_comb begin
		ch_d = ch_q;
		if (wr_en) begin
			ch_d = last ? '0 : ch_inc[CH_W-1:0];
		end
	end

	assign res.sample = word;
	assign res.channel = 7'(ch_q);
	assign res.last_of_point = last;
	assign res.point_all_zero = last && drop;

	mcdsd_ram #(
		.WIDTH(16),
		.DEPTH(MAX_CHANNELS)
	) u_values (
		.clk   (clk),
		.we    (wr_en),
		.waddr (ch_q),
		.wdata (word),
		.raddr (ch_d),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		byp_data_q <= word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else begin
			byp_q <= wr_en && (ch_d == ch_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_channels_q <= NUM_CHANNELS_RESET;
			zero_check_q <= 1'b0;
			segment_points_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NUM_CHANNELS: num_channels_q <= cfg_data[7:0];
				REG_ZERO_CHECK: zero_check_q <= cfg_data[0];
				REG_SEGMENT_POINTS: segment_points_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q <= '0;
			pend_q <= 1'b0;
			hi_q <= '0;
			abs_q <= 1'b1;
			allz_q <= 1'b1;
			seg_q <= '0;
		end else if (acc) begin
			if (start_abs) begin
				pend_q <= 1'b1;
				hi_q <= data_byte;
			end else begin
				pend_q <= 1'b0;
				ch_q <= ch_d;
				if (last) begin
					allz_q <= 1'b1;
					if (!drop) begin
						if (segment_points_q != 16'd0 && seg_inc >= segment_points_q) begin
							seg_q <= '0;
							abs_q <= 1'b1;
						end else begin
							seg_q <= seg_inc;
							abs_q <= 1'b0;
						end
					end
				end else begin
					allz_q <= allz_n;
				end
			end
		end
	end

	assign pop = out_v_q && m_tready;

	always_ff @(posedge clk) begin
		if (sk_v_q) begin
			if (pop) begin
				out_q <= sk_q;
			end
		end else if (wr_en) begin
			if (!out_v_q || pop) begin
				out_q <= res;
			end else begin
				sk_q <= res;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			sk_v_q <= 1'b0;
		end else if (sk_v_q) begin
			if (pop) begin
				sk_v_q <= 1'b0;
			end
		end else if (wr_en) begin
			if (!out_v_q || pop) begin
				out_v_q <= 1'b1;
			end else begin
				sk_v_q <= 1'b1;
			end
		end else if (pop) begin
			out_v_q <= 1'b0;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata = {1'b0, out_q.channel, out_q.sample};
	assign m_tlast = out_q.last_of_point;
	assign m_tuser = out_q.point_all_zero;

`ifndef SYNTHESIS
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		sk_v_q |-> out_v_q)
		else $error("skid register holds a result while the output register is empty");

	a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sk_v_q) |-> $past(out_v_q && !m_tready))
		else $error("skid register filled without a stalled output");

	a_high_byte_pends: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && start_abs) |=> (pend_q && !wr_en) || (pend_q && wr_en))
		else $error("high byte of an absolute word not held");

	a_low_byte_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && pend_q) |=> !pend_q)
		else $error("pending high byte not cleared by its low byte");

	a_bypass_same_channel: assert property (@(posedge clk) disable iff (!arst_n)
		byp_q |-> $past(wr_en) && (ch_q == $past(ch_q)))
		else $error("value bypass taken without a write to the same channel");
`endif

endmodule

// ===== hw/rtl/mcdsd_ram.sv =====
module mcdsd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import mcdsd_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_OFF_CYCLES = 300;

	logic clk = 1'b0;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata;  // [7:0] data_byte
	logic m_tvalid;
	logic m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;  // [15:0] sample, [22:16] channel
	logic m_tlast;
	logic m_tuser;  // [0] point_all_zero
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Decoder state as the testbench expects it.
	logic [15:0] chan_value [MAX_CHANNELS];
	bit chan_written [MAX_CHANNELS];
	int cur_channel;
	bit word_pending;
	logic [7:0] word_high;
	bit need_absolute;
	bit point_zero;
	logic [15:0] seg_count;
	logic [7:0] cfg_channels;
	bit cfg_zero;
	logic [15:0] cfg_seg;

	result_t expected_samples [$];
	result_t head_sample;

	bit zero_mode;
	bit no_gaps;
	int hold_left;
	int stall_left;
	int quiet_cycles;
	int errors;
	int bytes_sent;
	int samples_seen;
	int point_ends;
	int zero_points;

	multichannel_delta_sample_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 70) return $urandom_range(1, 3);
		if (p < 95) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic bit decode_byte(input logic [7:0] b, output result_t r);
		int n;
		int ch;
		logic [15:0] word;
		bit last;
		bit drop;
		n = (cfg_channels == 0) ? 1 : (cfg_channels > MAX_CHANNELS) ? MAX_CHANNELS : cfg_channels;
		ch = (cur_channel >= MAX_CHANNELS) ? MAX_CHANNELS - 1 : cur_channel;
		r = '0;
		drop = 1'b0;
		if (word_pending) begin
			word = {word_high, b};
			if (!word[14]) word[15] = 1'b0;
			word_pending = 1'b0;
		end else if (b[7] || need_absolute) begin
			word_high = b;
			word_pending = 1'b1;
			return 1'b0;
		end else begin
			word = chan_value[ch] + {{9{b[6]}}, b[6:0]};
		end
		chan_value[ch] = word;
		chan_written[ch] = 1'b1;
		if (word != 16'd0) point_zero = 1'b0;
		last = (ch + 1 >= n);
		if (last) begin
			drop = cfg_zero && point_zero;
			point_zero = 1'b1;
			cur_channel = 0;
			if (!drop) begin
				need_absolute = 1'b0;
				seg_count = seg_count + 16'd1;
				if (cfg_seg != 16'd0 && seg_count >= cfg_seg) begin
					seg_count = 16'd0;
					need_absolute = 1'b1;
				end
			end
		end else begin
			cur_channel = ch + 1;
		end
		r.sample = word;
		r.channel = ch[6:0];
		r.last_of_point = last;
		r.point_all_zero = drop;
		return 1'b1;
	endfunction

	// Chooses a well-formed next byte for the current decoder state. A channel
	// that was never written always gets an absolute word.
	function automatic logic [7:0] pick_byte();
		int ch;
		logic [15:0] neg;
		ch = (cur_channel >= MAX_CHANNELS) ? MAX_CHANNELS - 1 : cur_channel;
		if (word_pending || need_absolute)
			return zero_mode ? 8'h00 : 8'($urandom_range(0, 255));
		if (!chan_written[ch] || $urandom_range(0, 9) == 0)
			return zero_mode ? 8'h80 : (8'h80 | 8'($urandom_range(0, 127)));
		if (zero_mode) begin
			neg = 16'd0 - chan_value[ch];
			if (neg < 16'd64 || neg >= 16'hffc0) return {1'b0, neg[6:0]};
			return 8'h80;
		end
		return 8'($urandom_range(0, 127));
	endfunction

	task automatic report_mismatch(input string field, input int got, input int want);
		$display("Mismatch in %s at sample %0d: got 0x%0h, expected 0x%0h",
			field, samples_seen, got, want);
		errors++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		result_t r;
		int gap;
		gap = (!no_gaps && $urandom_range(0, 3) == 0) ? gap_len() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
		if (decode_byte(b, r)) expected_samples.push_back(r);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (expected_samples.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_NUM_CHANNELS: cfg_channels = data[7:0];
			REG_ZERO_CHECK: cfg_zero = data[0];
			REG_SEGMENT_POINTS: cfg_seg = data;
			default: ;
		endcase
	endtask

	// Unused upper bits of the narrow registers carry random values.
	task automatic configure(input int channels, input bit zero_on, input int seg);
		write_reg(REG_NUM_CHANNELS, {8'($urandom_range(0, 255)), 8'(channels)});
		write_reg(REG_ZERO_CHECK, {15'($urandom_range(0, 32767)), zero_on});
		write_reg(REG_SEGMENT_POINTS, 16'(seg));
	endtask

	task automatic run_random(input int count, input int zero_pct);
		int k;
		k = 0;
		while (k < count || cur_channel != 0 || word_pending) begin
			if (cur_channel == 0 && !word_pending)
				zero_mode = ($urandom_range(0, 99) < zero_pct);
			send_byte(pick_byte());
			k++;
			if ($urandom_range(0, 199) == 0) drain();
		end
		zero_mode = 1'b0;
		drain();
	endtask

	task automatic test_reset_defaults();
		run_random(100, 20);
	endtask

	task automatic test_absolute_words();
		configure(3, 1'b0, 1);
		run_random(1, 0);
		write_reg(REG_SEGMENT_POINTS, 16'd0);
		send_byte(8'hff); send_byte(8'hff);
		send_byte(8'h7f); send_byte(8'hff);
		send_byte(8'h3f); send_byte(8'h80);
		send_byte(8'h01);
		send_byte(8'h01);
		send_byte(8'h40);
		send_byte(8'h81); send_byte(8'h23);
		send_byte(8'hc0); send_byte(8'h01);
		send_byte(8'h3f);
		send_byte(8'h7f);
		send_byte(8'h80); send_byte(8'h80);
		send_byte(8'h00);
		drain();
	endtask

	task automatic test_zero_drop();
		configure(1, 1'b1, 1);
		send_byte(8'h80); send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'h05);
		send_byte(8'h00); send_byte(8'h00);
		send_byte(8'h00); send_byte(8'h07);
		drain();
	endtask

	task automatic test_channel_change();
		configure(4, 1'b0, 0);
		while (cur_channel != 3 || word_pending) send_byte(pick_byte());
		drain();
		write_reg(REG_NUM_CHANNELS, 16'd2);
		run_random(4, 0);
	endtask

	task automatic test_random_settings();
		configure(1, 1'b1, 3);
		run_random(80, 50);
		configure(128, 1'b0, 2);
		run_random(200, 10);
		configure(0, 1'b1, 0);
		run_random(60, 40);
		configure(255, 1'b0, 65535);
		run_random(100, 5);
		configure(5, 1'b1, 1);
		run_random(80, 50);
		configure(7, 1'b0, 0);
		no_gaps = 1'b1;
		run_random(100, 0);
		no_gaps = 1'b0;
	endtask

	task automatic test_back_pressure();
		configure(3, 1'b0, 0);
		hold_left = HOLD_OFF_CYCLES;
		no_gaps = 1'b1;
		run_random(60, 0);
		no_gaps = 1'b0;
	endtask

	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left = hold_left - 1;
		end else if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left = stall_left - 1;
		end else begin
			m_tready <= 1'b1;
			if (!no_gaps && $urandom_range(0, 5) == 0) stall_left = gap_len();
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_samples.size() == 0) begin
				report_mismatch("unexpected sample", m_tdata, 0);
			end else begin
				head_sample = expected_samples.pop_front();
				if (m_tdata[15:0] !== head_sample.sample)
					report_mismatch("sample", m_tdata[15:0], head_sample.sample);
				if (m_tdata[22:16] !== head_sample.channel)
					report_mismatch("channel", m_tdata[22:16], head_sample.channel);
				if (m_tdata[23] !== 1'b0)
					report_mismatch("tdata padding", m_tdata[23], 0);
				if (m_tlast !== head_sample.last_of_point)
					report_mismatch("last_of_point", m_tlast, head_sample.last_of_point);
				if (m_tuser !== head_sample.point_all_zero)
					report_mismatch("point_all_zero", m_tuser, head_sample.point_all_zero);
			end
			samples_seen++;
			if (m_tlast === 1'b1) point_ends++;
			if (m_tuser === 1'b1) zero_points++;
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			quiet_cycles = 0;
		else
			quiet_cycles = quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Timeout after %0d cycles without a transfer", STALL_LIMIT);
			$display("FAIL multichannel_delta_sample_decoder");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		for (int i = 0; i < MAX_CHANNELS; i++) begin
			chan_value[i] = 16'd0;
			chan_written[i] = 1'b0;
		end
		cur_channel = 0;
		word_pending = 1'b0;
		word_high = 8'd0;
		need_absolute = 1'b1;
		point_zero = 1'b1;
		seg_count = 16'd0;
		cfg_channels = NUM_CHANNELS_RESET;
		cfg_zero = 1'b0;
		cfg_seg = 16'd0;
		zero_mode = 1'b0;
		no_gaps = 1'b0;
		hold_left = 0;
		stall_left = 0;
		quiet_cycles = 0;
		errors = 0;
		bytes_sent = 0;
		samples_seen = 0;
		point_ends = 0;
		zero_points = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_absolute_words();
		test_zero_drop();
		test_channel_change();
		test_random_settings();
		test_back_pressure();
		drain();
		$display("Decoded %0d stream bytes into %0d samples: %0d point ends, %0d dropped points.",
			bytes_sent, samples_seen, point_ends, zero_points);
		$display("Channel counts 0 to 255, zero check on and off, segments up to 65535 points, %s",
			"a long output hold-off and a mid-point channel count change.");
		if (errors == 0) begin
			$display("PASS multichannel_delta_sample_decoder");
		end else begin
			$display("FAIL multichannel_delta_sample_decoder");
		end
		$finish;
	end

endmodule
